// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/cbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_pkg
// Widths, payload words and divider handshake types of the Bezier tessellator.
// ----------------------------------------------------------------------------
package cbt_pkg;

   localparam int COORD_BITS = 16;
   localparam int STEP_BITS  = 6;
   localparam int SQ_BITS    = 2 * STEP_BITS;
   // weights are third-degree products of step counts, at most m^3
   localparam int WGT_BITS   = 3 * STEP_BITS;
   localparam int PROD_BITS  = WGT_BITS + COORD_BITS + 1;
   localparam int ACC_BITS   = PROD_BITS;
   localparam int NUM_BITS   = PROD_BITS;
   localparam int CNT_BITS   = $clog2(COORD_BITS + 1);
   localparam int NUM_TERMS  = 4;
   localparam int NUM_AXES   = 3;

   localparam logic [STEP_BITS-1:0]  STEPS_RESET = STEP_BITS'(60);
   localparam logic [COORD_BITS-1:0] SIGN_MASK   = COORD_BITS'(1) << (COORD_BITS - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type ctrl1_x;
      coord_type ctrl1_y;
      coord_type ctrl1_z;
      coord_type ctrl2_x;
      coord_type ctrl2_y;
      coord_type ctrl2_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
   } req_type;

   typedef struct packed {
      coord_type            pos_x;
      coord_type            pos_y;
      coord_type            pos_z;
      logic [STEP_BITS-1:0] sample_index;
      logic                 last_sample;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] num;
      logic [WGT_BITS:0]   den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] quo;
   } div_rsp_type;

endpackage

// ----- rtl/cbt_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_mul
// Shared registered multiplier: unsigned weight times signed coordinate.
// ----------------------------------------------------------------------------
module cbt_mul (
   input  logic                                    clock,
   input  logic [cbt_pkg::WGT_BITS-1:0]            mul_a,
   input  logic signed [cbt_pkg::COORD_BITS-1:0]   mul_b,
   output logic signed [cbt_pkg::PROD_BITS-1:0]    prod_ff
);
   import cbt_pkg::*;

   logic signed [PROD_BITS-1:0] prod_in;

   always_comb begin
      prod_in = $signed({1'b0, mul_a}) * mul_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/cbt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module cbt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cbt_pkg::div_req_type div_req,
   output cbt_pkg::div_rsp_type div_rsp
);
   import cbt_pkg::*;

   `include "assert_macros.svh"

   logic [NUM_BITS-1:0]   rem_ff, rem_in;
   logic [NUM_BITS-1:0]   dsh_ff, dsh_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   always_comb begin
      logic qbit;
      qbit    = 1'b0;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = div_req.num;
         dsh_in = NUM_BITS'(div_req.den) << (COORD_BITS - 1);
         quo_in = '0;
         cnt_in = CNT_BITS'(COORD_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            qbit   = 1'b1;
         end
         quo_in = {quo_ff[COORD_BITS-2:0], qbit};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

   `ASSERT_IMPL(a_div_no_restart, div_req.start, !run_ff)
   `ASSERT_IMPL(a_div_done_stopped, done_ff, !run_ff)
   `ASSERT_IMPL(a_div_count_live, run_ff, cnt_ff != '0)

endmodule

// ----- rtl/cubic_bezier_tessellator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_unit
// Samples a cubic Bezier segment at m+1 evenly spaced steps, rounded exactly.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+----------------------------
//   request | start, busy, req_payload       | taken when start && !busy
//   result  | rsp_strobe, rsp_payload        | one-cycle strobe, no stall
//   csr     | csr_valid, csr_ready, csr_data | written when valid && ready
//
// Each sample runs the weight products (WSS through WSTORE), then per axis
// one MAC step per control point, one drain, one divider load and the
// divider run, then one emit step. The shared multiplier and the
// bit-serial divider set how long a segment takes.
// Reset is synchronous; it returns the step count to 60 and idles the block.
// Results cannot be stalled; busy stays high until the last sample leaves.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cbt_pkg::req_type                  req_payload,
   output logic                              rsp_strobe,
   output cbt_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbt_pkg::STEP_BITS-1:0]     csr_data
);
   import cbt_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_WSS    = 12'b0000_0000_0010,
      S_WS3    = 12'b0000_0000_0100,
      S_WS2J   = 12'b0000_0000_1000,
      S_WJJ    = 12'b0000_0001_0000,
      S_WJ3    = 12'b0000_0010_0000,
      S_WJ2S   = 12'b0000_0100_0000,
      S_WSTORE = 12'b0000_1000_0000,
      S_MAC    = 12'b0001_0000_0000,
      S_DRAIN  = 12'b0010_0000_0000,
      S_LOAD   = 12'b0100_0000_0000,
      S_EMIT   = 12'b1000_0000_0000
   } state_type;

   function automatic logic [WGT_BITS-1:0] times3(input logic [WGT_BITS-1:0] x);
      times3 = (x << 1) + x;
   endfunction

   state_type             state_ff, state_in;
   logic                  div_wait_ff, div_wait_in;
   logic [STEP_BITS-1:0]  csr_steps_ff, csr_steps_in;
   logic [STEP_BITS-1:0]  m_ff, m_in;
   logic [STEP_BITS-1:0]  j_ff, j_in;
   logic [1:0]            term_ff, term_in;
   logic [1:0]            coord_ff, coord_in;
   logic [SQ_BITS-1:0]    s2_ff, s2_in;
   logic [SQ_BITS-1:0]    j2_ff, j2_in;
   logic [WGT_BITS-1:0]   m3_ff, m3_in;
   logic [WGT_BITS-1:0]   w_ff [NUM_TERMS];
   logic [WGT_BITS-1:0]   w_in [NUM_TERMS];
   coord_type             pts_ff [NUM_TERMS][NUM_AXES];
   coord_type             pts_in [NUM_TERMS][NUM_AXES];
   coord_type             pos_ff [NUM_AXES];
   coord_type             pos_in [NUM_AXES];
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;

   logic [STEP_BITS-1:0]        s_step;
   logic [WGT_BITS-1:0]         mul_a;
   logic signed [COORD_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0] prod_ff;
   div_req_type                 div_req;
   div_rsp_type                 div_rsp;

   cbt_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   cbt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign s_step = m_ff - j_ff;

   always_comb begin
      state_in     = state_ff;
      div_wait_in  = div_wait_ff;
      csr_steps_in = csr_steps_ff;
      m_in         = m_ff;
      j_in         = j_ff;
      term_in      = term_ff;
      coord_in     = coord_ff;
      s2_in        = s2_ff;
      j2_in        = j2_ff;
      m3_in        = m3_ff;
      w_in         = w_ff;
      pts_in       = pts_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req.start = 1'b0;
      // num = 2P + m^3 + m^3 * 2^COORD_BITS: the offset keeps it nonnegative
      div_req.num   = NUM_BITS'({acc_ff[ACC_BITS-2:0], 1'b0}) + NUM_BITS'(m3_ff)
                    + (NUM_BITS'(m3_ff) << COORD_BITS);
      div_req.den   = {m3_ff, 1'b0};

      if (csr_valid && csr_ready) begin
         csr_steps_in = csr_data;
      end

      if (div_wait_ff) begin
         // hold until the quotient is back; undo the offset by flipping the sign bit
         if (div_rsp.done) begin
            div_wait_in      = 1'b0;
            pos_in[coord_ff] = $signed(div_rsp.quo ^ SIGN_MASK);
            if (coord_ff == 2'(NUM_AXES - 1)) begin
               state_in = S_EMIT;
            end else begin
               coord_in = coord_ff + 2'd1;
               term_in  = '0;
               state_in = S_MAC;
            end
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  pts_in[0][0] = req_payload.start_x;
                  pts_in[0][1] = req_payload.start_y;
                  pts_in[0][2] = req_payload.start_z;
                  pts_in[1][0] = req_payload.ctrl1_x;
                  pts_in[1][1] = req_payload.ctrl1_y;
                  pts_in[1][2] = req_payload.ctrl1_z;
                  pts_in[2][0] = req_payload.ctrl2_x;
                  pts_in[2][1] = req_payload.ctrl2_y;
                  pts_in[2][2] = req_payload.ctrl2_z;
                  pts_in[3][0] = req_payload.end_x;
                  pts_in[3][1] = req_payload.end_y;
                  pts_in[3][2] = req_payload.end_z;
                  // zero steps behaves as one
                  m_in     = (csr_steps_ff == '0) ? STEP_BITS'(1) : csr_steps_ff;
                  j_in     = '0;
                  state_in = S_WSS;
               end
            end
            S_WSS: begin
               mul_a    = WGT_BITS'(s_step);
               mul_b    = COORD_BITS'(s_step);
               state_in = S_WS3;
            end
            S_WS3: begin
               s2_in    = prod_ff[SQ_BITS-1:0];
               mul_a    = WGT_BITS'(prod_ff[SQ_BITS-1:0]);
               mul_b    = COORD_BITS'(s_step);
               state_in = S_WS2J;
            end
            S_WS2J: begin
               w_in[0]  = prod_ff[WGT_BITS-1:0];
               mul_a    = WGT_BITS'(s2_ff);
               mul_b    = COORD_BITS'(j_ff);
               state_in = S_WJJ;
            end
            S_WJJ: begin
               w_in[1]  = times3(prod_ff[WGT_BITS-1:0]);
               mul_a    = WGT_BITS'(j_ff);
               mul_b    = COORD_BITS'(j_ff);
               state_in = S_WJ3;
            end
            S_WJ3: begin
               j2_in    = prod_ff[SQ_BITS-1:0];
               mul_a    = WGT_BITS'(prod_ff[SQ_BITS-1:0]);
               mul_b    = COORD_BITS'(j_ff);
               state_in = S_WJ2S;
            end
            S_WJ2S: begin
               w_in[3]  = prod_ff[WGT_BITS-1:0];
               mul_a    = WGT_BITS'(j2_ff);
               mul_b    = COORD_BITS'(s_step);
               state_in = S_WSTORE;
            end
            S_WSTORE: begin
               w_in[2] = times3(prod_ff[WGT_BITS-1:0]);
               // at the first sample s equals m, so its cube is the divisor base
               if (j_ff == '0) begin
                  m3_in = w_ff[0];
               end
               term_in  = '0;
               coord_in = '0;
               state_in = S_MAC;
            end
            S_MAC: begin
               mul_a   = w_ff[term_ff];
               mul_b   = pts_ff[term_ff][coord_ff];
               acc_in  = (term_ff == '0) ? '0 : acc_ff + prod_ff;
               term_in = term_ff + 2'd1;
               if (term_ff == 2'(NUM_TERMS - 1)) begin
                  state_in = S_DRAIN;
               end
            end
            S_DRAIN: begin
               acc_in   = acc_ff + prod_ff;
               state_in = S_LOAD;
            end
            S_LOAD: begin
               div_req.start = 1'b1;
               div_wait_in   = 1'b1;
            end
            S_EMIT: begin
               if (j_ff == m_ff) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + STEP_BITS'(1);
                  state_in = S_WSS;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_wait_ff  <= 1'b0;
         csr_steps_ff <= STEPS_RESET;
         m_ff         <= STEP_BITS'(1);
         j_ff         <= '0;
         term_ff      <= '0;
         coord_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         div_wait_ff  <= div_wait_in;
         csr_steps_ff <= csr_steps_in;
         m_ff         <= m_in;
         j_ff         <= j_in;
         term_ff      <= term_in;
         coord_ff     <= coord_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff  <= s2_in;
      j2_ff  <= j2_in;
      m3_ff  <= m3_in;
      w_ff   <= w_in;
      pts_ff <= pts_in;
      pos_ff <= pos_in;
      acc_ff <= acc_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_strobe = (state_ff == S_EMIT);

   assign rsp_payload.pos_x        = pos_ff[0];
   assign rsp_payload.pos_y        = pos_ff[1];
   assign rsp_payload.pos_z        = pos_ff[2];
   assign rsp_payload.sample_index = j_ff;
   assign rsp_payload.last_sample  = (j_ff == m_ff);

   `ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
   `ASSERT_NEXT(a_last_frees_block, rsp_strobe && rsp_payload.last_sample, !busy)
   `ASSERT_IMPL(a_steps_nonzero, busy, m_ff != '0)
   `ASSERT_IMPL(a_wait_in_load, div_wait_ff, state_ff == S_LOAD)

endmodule
